// ===== design/spq_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and controller codes of the stable priority queue.
package spq_pkg;

	localparam int unsigned DEF_CAPACITY = 16;
	localparam int unsigned PRIO_W = 16;
	localparam int unsigned PAY_W = 32;
	localparam int unsigned OCC_W = 5;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_REMOVE = 1'b1;

	typedef struct packed {
		logic              opcode;
		logic [PRIO_W-1:0] priority_req;
		logic [PAY_W-1:0]  payload;
	} req_t;

	typedef struct packed {
		logic              out_valid;
		logic [PRIO_W-1:0] out_priority;
		logic [PAY_W-1:0]  out_payload;
		logic              overflow;
		logic [OCC_W-1:0]  occupancy;
	} rsp_t;

	typedef struct packed {
		logic [PRIO_W-1:0] prio;
		logic [PAY_W-1:0]  pay;
	} entry_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_CMP,
		ST_READ,
		ST_WRITE_NEW,
		ST_RESULT
	} state_t;

	typedef enum logic [1:0] {
		RES_INS,
		RES_OVF,
		RES_EMPTY,
		RES_POP
	} res_kind_t;

	typedef struct packed {
		logic      load_in;
		logic      rd_prev;
		logic      rd_head;
		logic      wr_shift;
		logic      wr_new;
		logic      push;
		res_kind_t kind;
	} cmd_t;

	typedef struct packed {
		logic is_remove;
		logic full;
		logic empty;
		logic left_one;
		logic older_gt;
		logic out_free;
	} status_t;

endpackage

// ===== design/spq_chan_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interface carrying one beat of a typed payload.
interface spq_chan_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== design/spq_ctrl.sv =====
`timescale 1ns / 1ps
// Controller state machine sequencing inserts, removes and result beats.
module spq_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_ready,
	input  spq_pkg::status_t status,
	output spq_pkg::cmd_t    cmd
);

	spq_pkg::state_t    state_q, state_d;
	spq_pkg::res_kind_t kind_q, kind_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= spq_pkg::ST_IDLE;
			kind_q  <= spq_pkg::RES_INS;
		end else begin
			state_q <= state_d;
			kind_q  <= kind_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		kind_d    = kind_q;
		req_ready = 1'b0;
		cmd       = '0;
		cmd.kind  = kind_q;
		case (state_q)
			spq_pkg::ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.load_in = 1'b1;
					state_d     = spq_pkg::ST_DISPATCH;
				end
			end
			spq_pkg::ST_DISPATCH: begin
				if (status.is_remove) begin
					if (status.empty) begin
						kind_d = spq_pkg::RES_EMPTY;
					end else begin
						cmd.rd_head = 1'b1;
						kind_d      = spq_pkg::RES_POP;
					end
					state_d = spq_pkg::ST_RESULT;
				end else if (status.full) begin
					kind_d  = spq_pkg::RES_OVF;
					state_d = spq_pkg::ST_RESULT;
				end else if (status.empty) begin
					state_d = spq_pkg::ST_WRITE_NEW;
				end else begin
					cmd.rd_prev = 1'b1;
					state_d     = spq_pkg::ST_CMP;
				end
			end
			spq_pkg::ST_CMP: begin
				if (status.older_gt) begin
					cmd.wr_shift = 1'b1;
					state_d = status.left_one ? spq_pkg::ST_WRITE_NEW : spq_pkg::ST_READ;
				end else begin
					state_d = spq_pkg::ST_WRITE_NEW;
				end
			end
			spq_pkg::ST_READ: begin
				cmd.rd_prev = 1'b1;
				state_d     = spq_pkg::ST_CMP;
			end
			spq_pkg::ST_WRITE_NEW: begin
				cmd.wr_new = 1'b1;
				kind_d     = spq_pkg::RES_INS;
				state_d    = spq_pkg::ST_RESULT;
			end
			spq_pkg::ST_RESULT: begin
				if (status.out_free) begin
					cmd.push = 1'b1;
					state_d  = spq_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = spq_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

// ===== design/spq_dp.sv =====
`timescale 1ns / 1ps
// Datapath: circular sorted entry memory, head and count, insert cursor, result register.
module spq_dp #(
	parameter int unsigned CAPACITY = spq_pkg::DEF_CAPACITY
) (
	input  logic              clk,
	input  logic              arst_n,
	input  spq_pkg::req_t     req_data,
	input  spq_pkg::cmd_t     cmd,
	output spq_pkg::status_t  status,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output spq_pkg::rsp_t     rsp_data
);

	localparam int unsigned IDX_W = $clog2(CAPACITY);
	localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
	localparam int unsigned SUM_W = IDX_W + 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);
	localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);
	localparam logic [SUM_W-1:0] CAP_SUM = SUM_W'(CAPACITY);

	spq_pkg::entry_t mem [CAPACITY];
	spq_pkg::entry_t rdata_q;
	spq_pkg::entry_t wr_data;
	spq_pkg::req_t   req_q;
	spq_pkg::rsp_t   rsp_q, rsp_d;
	logic            rsp_valid_q;

	logic [IDX_W-1:0] head_q, cur_q;
	logic [CNT_W-1:0] count_q, left_q;
	logic [IDX_W-1:0] cur_prev, head_next, tail_idx, rd_idx, wr_idx;
	logic [SUM_W-1:0] tail_sum, tail_wrap;
	logic             rd_en, wr_en;

	assign cur_prev  = (cur_q == '0) ? LAST_IDX : cur_q - 1'b1;
	assign head_next = (head_q == LAST_IDX) ? '0 : head_q + 1'b1;
	assign tail_sum  = SUM_W'(head_q) + SUM_W'(count_q);
	assign tail_wrap = tail_sum - CAP_SUM;
	assign tail_idx  = (tail_sum >= CAP_SUM) ? tail_wrap[IDX_W-1:0] : tail_sum[IDX_W-1:0];

	assign rd_en   = cmd.rd_prev | cmd.rd_head;
	assign rd_idx  = cmd.rd_head ? head_q : cur_prev;
	assign wr_en   = cmd.wr_shift | cmd.wr_new;
	assign wr_idx  = cur_q;
	assign wr_data = cmd.wr_new ? spq_pkg::entry_t'({req_q.priority_req, req_q.payload})
		: rdata_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_idx] <= wr_data;
		end
		if (rd_en) begin
			rdata_q <= mem[rd_idx];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			req_q <= req_data;
		end
		if (cmd.push) begin
			rsp_q <= rsp_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			count_q     <= '0;
			cur_q       <= '0;
			left_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd.load_in) begin
				cur_q  <= tail_idx;
				left_q <= count_q;
			end else if (cmd.wr_shift) begin
				cur_q  <= cur_prev;
				left_q <= left_q - 1'b1;
			end
			if (cmd.wr_new) begin
				count_q <= count_q + 1'b1;
			end else if (cmd.push && cmd.kind == spq_pkg::RES_POP) begin
				count_q <= count_q - 1'b1;
				head_q  <= head_next;
			end
			if (cmd.push) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		rsp_d           = '0;
		rsp_d.occupancy = spq_pkg::OCC_W'(count_q);
		case (cmd.kind)
			spq_pkg::RES_POP: begin
				rsp_d.out_valid    = 1'b1;
				rsp_d.out_priority = rdata_q.prio;
				rsp_d.out_payload  = rdata_q.pay;
				rsp_d.occupancy    = spq_pkg::OCC_W'(count_q - 1'b1);
			end
			spq_pkg::RES_OVF: begin
				rsp_d.overflow = 1'b1;
			end
			default: begin
				rsp_d.out_valid = 1'b0;
			end
		endcase
	end

	assign status.is_remove = (req_q.opcode == spq_pkg::OP_REMOVE);
	assign status.full      = (count_q == CAP_CNT);
	assign status.empty     = (count_q == '0);
	assign status.left_one  = (left_q == CNT_W'(1));
	assign status.older_gt  = (rdata_q.prio > req_q.priority_req);
	assign status.out_free  = !rsp_valid_q || rsp_ready;

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

endmodule

// ===== design/stable_priority_queue_core.sv =====
`timescale 1ns / 1ps
// Top level of the stable priority queue: controller, datapath and channel hookup.
//
//  channel | role   | beat carries
//  --------+--------+----------------------------------------------------------
//  req     | sink   | opcode, priority_req, payload
//  rsp     | source | out_valid, out_priority, out_payload, overflow, occupancy
//
// One item is worked on at a time: a new req beat is accepted only once the last result is pushed.
// A remove reads the head entry; an insert into a full queue gives an overflow result. An insert
// walks down from the tail: each older entry of greater priority costs one read and one
// compare-and-write and moves up a slot, then the new entry is written into the freed slot.
// The result register lets a new beat be accepted while the previous result is unread.
// A stalled rsp holds the controller in its result state. arst_n empties the queue.
module stable_priority_queue_core #(
	parameter int unsigned CAPACITY = spq_pkg::DEF_CAPACITY
) (
	input logic         clk,
	input logic         arst_n,
	spq_chan_if.sink    req,
	spq_chan_if.source  rsp
);

	spq_pkg::cmd_t    cmd;
	spq_pkg::status_t status;

	spq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.status    (status),
		.cmd       (cmd)
	);

	spq_dp #(
		.CAPACITY (CAPACITY)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_data  (req.data),
		.cmd       (cmd),
		.status    (status),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.rsp_data  (rsp.data)
	);

endmodule

// ===== design/spq_checker.sv =====
`timescale 1ns / 1ps
// Port-level checker for the stable priority queue and its bind to the top level.
module spq_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          req_valid,
	input logic          req_ready,
	input logic          rsp_valid,
	input logic          rsp_ready,
	input spq_pkg::rsp_t rsp_data
);

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("Request accepted while the previous one is still in work.");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
		else $error("Stalled result beat changed.");

	a_no_entry_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_data.out_valid |->
			rsp_data.out_priority == '0 && rsp_data.out_payload == '0)
		else $error("Result without an entry carries nonzero fields.");

	a_ovf_no_entry: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data.overflow |-> !rsp_data.out_valid)
		else $error("Overflow beat also returns an entry.");

endmodule

bind stable_priority_queue_core spq_checker u_spq_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req.valid),
	.req_ready (req.ready),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.rsp_data  (rsp.data)
);
